/* rtl/core/assert_macros.svh */
// assertion macros of the scheduler rtl
// no dependencies; included by atss_dp, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/atss_pkg.sv */
// types and constants of the aging task state scheduler
// no dependencies; used by atss_ctrl, atss_dp and the top level
package atss_pkg;

    localparam int TASKS_DEF    = 32;
    localparam int AGE_BITS_DEF = 16;
    localparam int NUM_W        = 16;
    localparam int SLOT_W       = 5;
    localparam int ST_W         = 3;
    localparam int RSN_W        = 3;
    localparam int STS_W        = 2;

    // slot states
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd0;
    localparam logic [ST_W-1:0] ST_RUNNING   = 3'd1;
    localparam logic [ST_W-1:0] ST_RUNNABLE  = 3'd2;
    localparam logic [ST_W-1:0] ST_STOPPED   = 3'd3;
    localparam logic [ST_W-1:0] ST_WAITSLEEP = 3'd4;
    localparam logic [ST_W-1:0] ST_SLEEP     = 3'd5;
    localparam logic [ST_W-1:0] ST_EXITED    = 3'd6;

    // stop reasons
    localparam logic [RSN_W-1:0] RSN_PREEMPT = 3'd0;
    localparam logic [RSN_W-1:0] RSN_EXIT    = 3'd1;
    localparam logic [RSN_W-1:0] RSN_WAIT    = 3'd2;
    localparam logic [RSN_W-1:0] RSN_SEGV    = 3'd3;
    localparam logic [RSN_W-1:0] RSN_STOP    = 3'd4;
    localparam logic [RSN_W-1:0] RSN_SLEEP   = 3'd5;

    // result status
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_NORUN = 2'd2;
    localparam logic [STS_W-1:0] STS_NONE  = 2'd3;

    // operations
    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef struct packed {
        logic capture;
        logic find;
        logic retire;
        logic wake;
        logic age;
        logic pick;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic find_hit;
        logic find_last;
        logic exit_wake;
        logic wake_last;
        logic age_end;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/aging_task_state_scheduler.sv */
// Longest-wait-first task scheduler over a table of TASKS slots. One item is
// worked at a time by a sequencer that walks the slot table and the runnable
// queue one entry per cycle. A submit walks the slots up to the lowest empty
// one (all TASKS slots when the table is full). A schedule retires the running
// task, searches all TASKS slots for sleepers when it exits, then ages the
// runnable queue and picks its oldest entry. The result sits in an output
// register, so a new item is taken while the previous result waits downstream.
// depends on atss_pkg, atss_ctrl and atss_dp
module aging_task_state_scheduler #(
    parameter int TASKS    = atss_pkg::TASKS_DEF,
    parameter int AGE_BITS = atss_pkg::AGE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [atss_pkg::NUM_W-1:0]    i_task_num,
    input  logic [atss_pkg::RSN_W-1:0]    i_stop_reason,
    input  logic [atss_pkg::NUM_W-1:0]    i_wait_task_num,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [atss_pkg::STS_W-1:0]    o_status,
    output logic [atss_pkg::SLOT_W-1:0]   o_submit_slot,
    output logic [atss_pkg::SLOT_W-1:0]   o_chosen_slot,
    output logic                          o_chosen_valid,
    output logic [31:0]                   o_switch_count
);

    atss_pkg::t_dp_cmd  w_cmd;
    atss_pkg::t_dp_stat w_stat;

    atss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    atss_dp #(
        .TASKS    (TASKS),
        .AGE_BITS (AGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_task_num      (i_task_num),
        .i_stop_reason   (i_stop_reason),
        .i_wait_task_num (i_wait_task_num),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_submit_slot   (o_submit_slot),
        .o_chosen_slot   (o_chosen_slot),
        .o_chosen_valid  (o_chosen_valid),
        .o_switch_count  (o_switch_count)
    );

endmodule

/* rtl/core/atss_ctrl.sv */
// sequencer of the aging task state scheduler
// depends on atss_pkg; drives atss_dp through command and status structs
module atss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_op,
    output logic                o_ready,
    output atss_pkg::t_dp_cmd   o_cmd,
    input  atss_pkg::t_dp_stat  i_stat
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FIND   = 7'b0000010,
        S_RETIRE = 7'b0000100,
        S_WAKE   = 7'b0001000,
        S_AGE    = 7'b0010000,
        S_PICK   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_op == atss_pkg::OP_SUBMIT) ? S_FIND : S_RETIRE;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                if (i_stat.find_hit || i_stat.find_last) begin
                    n_state = S_DONE;
                end
            end
            S_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state = i_stat.exit_wake ? S_WAKE : S_AGE;
            end
            S_WAKE: begin
                o_cmd.wake = 1'b1;
                if (i_stat.wake_last) begin
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                if (i_stat.age_end) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/atss_dp.sv */
// slot table, runnable queue and result register of the scheduler
// depends on atss_pkg and assert_macros.svh; sequenced by atss_ctrl
`include "assert_macros.svh"

module atss_dp #(
    parameter int TASKS    = atss_pkg::TASKS_DEF,
    parameter int AGE_BITS = atss_pkg::AGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  atss_pkg::t_dp_cmd                 i_cmd,
    output atss_pkg::t_dp_stat                o_stat,
    input  logic [atss_pkg::NUM_W-1:0]        i_task_num,
    input  logic [atss_pkg::RSN_W-1:0]        i_stop_reason,
    input  logic [atss_pkg::NUM_W-1:0]        i_wait_task_num,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [atss_pkg::STS_W-1:0]        o_status,
    output logic [atss_pkg::SLOT_W-1:0]       o_submit_slot,
    output logic [atss_pkg::SLOT_W-1:0]       o_chosen_slot,
    output logic                              o_chosen_valid,
    output logic [31:0]                       o_switch_count
);

    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CNT_W = $clog2(TASKS + 1);
    localparam int EXT_W = IDX_W + atss_pkg::SLOT_W;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // slot table
    logic [atss_pkg::ST_W-1:0]  r_st     [TASKS];
    logic [atss_pkg::NUM_W-1:0] r_number [TASKS];
    logic [atss_pkg::NUM_W-1:0] r_wait   [TASKS];
    logic [AGE_BITS-1:0]        r_age    [TASKS];
    // runnable queue in insertion order
    logic [IDX_W-1:0]           r_q      [TASKS];
    logic [CNT_W-1:0]           r_q_cnt;

    logic [CNT_W-1:0]           r_idx;
    logic                       r_run_vld;
    logic [IDX_W-1:0]           r_run_slot;
    logic                       r_had;
    logic [31:0]                r_total;
    logic [atss_pkg::NUM_W-1:0] r_tnum;
    logic [atss_pkg::RSN_W-1:0] r_reason;
    logic [atss_pkg::NUM_W-1:0] r_wnum;
    logic [atss_pkg::NUM_W-1:0] r_exit_num;
    logic                       r_best_vld;
    logic [IDX_W-1:0]           r_best;
    logic [AGE_BITS-1:0]        r_best_age;
    logic [IDX_W-1:0]           r_best_pos;
    logic [atss_pkg::STS_W-1:0] r_res_status;
    logic [IDX_W-1:0]           r_res_sub;
    logic [IDX_W-1:0]           r_res_chosen;
    logic                       r_res_cv;
    logic                       r_o_valid;
    logic [atss_pkg::STS_W-1:0] r_o_status;
    logic [atss_pkg::SLOT_W-1:0] r_o_sub;
    logic [atss_pkg::SLOT_W-1:0] r_o_chosen;
    logic                       r_o_cv;
    logic [31:0]                r_o_total;

    logic [IDX_W-1:0]           w_i;
    logic [IDX_W-1:0]           w_qs;
    logic [AGE_BITS-1:0]        w_age_inc;
    logic                       w_age_act;
    logic                       w_wake_hit;
    logic                       w_better;
    logic [EXT_W-1:0]           w_sub_ext;
    logic [EXT_W-1:0]           w_chosen_ext;

    // single write port per table column
    logic                       w_st_we;
    logic [IDX_W-1:0]           w_st_idx;
    logic [atss_pkg::ST_W-1:0]  w_st_val;
    logic                       w_age_we;
    logic [IDX_W-1:0]           w_age_idx;
    logic [AGE_BITS-1:0]        w_age_val;
    logic                       w_wt_we;
    logic [IDX_W-1:0]           w_wt_idx;
    logic [atss_pkg::NUM_W-1:0] w_wt_val;
    logic                       w_app;
    logic [IDX_W-1:0]           w_app_slot;
    logic                       w_take;

    assign w_i       = r_idx[IDX_W-1:0];
    assign w_qs      = r_q[w_i];
    assign w_age_act = (r_idx != r_q_cnt);
    assign w_age_inc = (r_age[w_qs] == AGE_MAX) ? r_age[w_qs] : r_age[w_qs] + 1'b1;
    assign w_better  = !r_best_vld || (w_age_inc > r_best_age);
    assign w_wake_hit = (r_st[w_i] == atss_pkg::ST_WAITSLEEP) && (r_wait[w_i] == r_exit_num);
    assign w_take    = i_cmd.pick && r_best_vld;
    assign w_sub_ext    = EXT_W'(r_res_sub);
    assign w_chosen_ext = EXT_W'(r_res_chosen);

    assign o_stat.find_hit  = (r_st[w_i] == atss_pkg::ST_EMPTY);
    assign o_stat.find_last = (w_i == IDX_W'(TASKS - 1));
    assign o_stat.exit_wake = r_run_vld && (r_reason == atss_pkg::RSN_EXIT);
    assign o_stat.wake_last = (w_i == IDX_W'(TASKS - 1));
    assign o_stat.age_end   = !w_age_act;
    assign o_stat.out_free  = !r_o_valid || i_ready;

    always_comb begin
        w_st_we    = 1'b0;
        w_st_idx   = w_i;
        w_st_val   = atss_pkg::ST_RUNNABLE;
        w_age_we   = 1'b0;
        w_age_idx  = w_i;
        w_age_val  = '0;
        w_wt_we    = 1'b0;
        w_wt_idx   = w_i;
        w_wt_val   = '0;
        w_app      = 1'b0;
        w_app_slot = w_i;
        if (i_cmd.find && o_stat.find_hit) begin
            w_st_we  = 1'b1;
            w_age_we = 1'b1;
            w_wt_we  = 1'b1;
            w_app    = 1'b1;
        end
        if (i_cmd.retire && r_run_vld) begin
            w_st_we    = 1'b1;
            w_st_idx   = r_run_slot;
            w_age_idx  = r_run_slot;
            w_wt_idx   = r_run_slot;
            w_app_slot = r_run_slot;
            case (r_reason) inside
                atss_pkg::RSN_EXIT, atss_pkg::RSN_SEGV: w_st_val = atss_pkg::ST_EXITED;
                atss_pkg::RSN_WAIT: begin
                    w_st_val = atss_pkg::ST_WAITSLEEP;
                    w_wt_we  = 1'b1;
                    w_wt_val = r_wnum;
                end
                atss_pkg::RSN_STOP:  w_st_val = atss_pkg::ST_STOPPED;
                atss_pkg::RSN_SLEEP: w_st_val = atss_pkg::ST_SLEEP;
                default: begin
                    w_age_we = 1'b1;
                    w_app    = 1'b1;
                end
            endcase
        end
        if (i_cmd.wake && w_wake_hit) begin
            w_st_we  = 1'b1;
            w_age_we = 1'b1;
            w_wt_we  = 1'b1;
            w_app    = 1'b1;
        end
        if (i_cmd.age && w_age_act) begin
            w_age_we  = 1'b1;
            w_age_idx = w_qs;
            w_age_val = w_age_inc;
        end
        if (w_take) begin
            w_st_we  = 1'b1;
            w_st_idx = r_best;
            w_st_val = atss_pkg::ST_RUNNING;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASKS; k++) begin
                r_st[k] <= atss_pkg::ST_EMPTY;
            end
            r_q_cnt   <= '0;
            r_run_vld <= 1'b0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_st_we) begin
                r_st[w_st_idx] <= w_st_val;
            end
            if (w_app) begin
                r_q_cnt <= r_q_cnt + 1'b1;
            end else if (w_take) begin
                r_q_cnt <= r_q_cnt - 1'b1;
            end
            if (i_cmd.retire) begin
                r_run_vld <= 1'b0;
            end else if (w_take) begin
                r_run_vld <= 1'b1;
            end
            if (w_take) begin
                r_total <= r_total + 32'd1;
            end
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_app) begin
            r_q[r_q_cnt[IDX_W-1:0]] <= w_app_slot;
        end
        if (w_take) begin
            // close the gap left by the chosen entry
            for (int k = 0; k < TASKS - 1; k++) begin
                if (IDX_W'(k) >= r_best_pos) begin
                    r_q[k] <= r_q[k + 1];
                end
            end
        end
        if (i_cmd.find && o_stat.find_hit) begin
            r_number[w_i] <= r_tnum;
        end
        if (w_age_we) begin
            r_age[w_age_idx] <= w_age_val;
        end
        if (w_wt_we) begin
            r_wait[w_wt_idx] <= w_wt_val;
        end

        if (i_cmd.capture) begin
            r_tnum       <= i_task_num;
            r_reason     <= i_stop_reason;
            r_wnum       <= i_wait_task_num;
            r_idx        <= '0;
            r_best_vld   <= 1'b0;
            r_res_status <= atss_pkg::STS_OK;
            r_res_sub    <= '0;
            r_res_chosen <= '0;
            r_res_cv     <= 1'b0;
        end
        if (i_cmd.find) begin
            r_idx <= r_idx + 1'b1;
            if (o_stat.find_hit) begin
                r_res_sub <= w_i;
            end else if (o_stat.find_last) begin
                r_res_status <= atss_pkg::STS_FULL;
            end
        end
        if (i_cmd.retire) begin
            r_had      <= r_run_vld;
            r_idx      <= '0;
            r_exit_num <= r_number[r_run_slot];
        end
        if (i_cmd.wake) begin
            r_idx <= o_stat.wake_last ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.age && w_age_act) begin
            r_idx <= r_idx + 1'b1;
            if (w_better) begin
                r_best_vld <= 1'b1;
                r_best     <= w_qs;
                r_best_age <= w_age_inc;
                r_best_pos <= w_i;
            end
        end
        if (i_cmd.pick) begin
            if (!r_had) begin
                r_res_status <= atss_pkg::STS_NORUN;
            end else if (!r_best_vld) begin
                r_res_status <= atss_pkg::STS_NONE;
            end
            if (r_best_vld) begin
                r_run_slot   <= r_best;
                r_res_chosen <= r_best;
                r_res_cv     <= 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_o_status <= r_res_status;
            r_o_sub    <= w_sub_ext[atss_pkg::SLOT_W-1:0];
            r_o_chosen <= w_chosen_ext[atss_pkg::SLOT_W-1:0];
            r_o_cv     <= r_res_cv;
            r_o_total  <= r_total;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_submit_slot  = r_o_sub;
    assign o_chosen_slot  = r_o_chosen;
    assign o_chosen_valid = r_o_cv;
    assign o_switch_count = r_o_total;

    `AST_ALWAYS(a_q_bound, i_clk, i_rst_n, r_q_cnt <= CNT_W'(TASKS), "queue count beyond table size")
    `AST_NEXT(a_take_runs, i_clk, i_rst_n, w_take, r_run_vld && (r_total == $past(r_total) + 32'd1), "switch not recorded")
    `AST_NEXT(a_retire_clears, i_clk, i_rst_n, i_cmd.retire, !r_run_vld, "running task not retired")

endmodule

/* tb/tb_aging_task_state_scheduler.sv */
// self-checking testbench of aging_task_state_scheduler: directed table then random traffic
// expected results come from its slot-table model or typed rows; depends on atss_pkg and the rtl
module tb_aging_task_state_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 32;
    localparam int N_RANDOM = 1130;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [atss_pkg::RSN_W-1:0] RSN_ODD6 = 3'd6;
    localparam logic [atss_pkg::RSN_W-1:0] RSN_ODD7 = 3'd7;

    typedef struct packed {
        logic [atss_pkg::STS_W-1:0]  status;
        logic [atss_pkg::SLOT_W-1:0] submit_slot;
        logic [atss_pkg::SLOT_W-1:0] chosen_slot;
        logic                        chosen_valid;
        logic [31:0]                 switch_count;
    } t_res;

    typedef struct {
        logic                       op;
        logic [atss_pkg::NUM_W-1:0] tnum;
        logic [atss_pkg::RSN_W-1:0] rsn;
        logic [atss_pkg::NUM_W-1:0] wnum;
        bit                         typed;
        t_res                       res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_op = 1'b0;
    logic [atss_pkg::NUM_W-1:0] i_task_num = '0;
    logic [atss_pkg::RSN_W-1:0] i_stop_reason = '0;
    logic [atss_pkg::NUM_W-1:0] i_wait_task_num = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [atss_pkg::STS_W-1:0] o_status;
    logic [atss_pkg::SLOT_W-1:0] o_submit_slot;
    logic [atss_pkg::SLOT_W-1:0] o_chosen_slot;
    logic o_chosen_valid;
    logic [31:0] o_switch_count;

    aging_task_state_scheduler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the slot table
    logic [atss_pkg::NUM_W-1:0] m_num [NSLOT];
    logic [atss_pkg::ST_W-1:0]  m_st  [NSLOT];
    logic [15:0]                m_age [NSLOT];
    logic [atss_pkg::NUM_W-1:0] m_wt  [NSLOT];
    int                         m_queue[$];
    int                         m_cur;
    logic [31:0]                m_switches;

    t_res pending[$];
    int   errors = 0;
    bit   no_gaps = 0;
    bit   hold_req = 0;

    function automatic void enter_runnable(int s);
        m_st[s] = atss_pkg::ST_RUNNABLE;
        m_age[s] = '0;
        m_queue.push_back(s);
    endfunction

    function automatic t_res schedule_step(logic op, logic [atss_pkg::NUM_W-1:0] tnum,
                                           logic [atss_pkg::RSN_W-1:0] rsn,
                                           logic [atss_pkg::NUM_W-1:0] wnum);
        t_res r;
        int s, c, best;
        logic [15:0] best_age;
        logic [atss_pkg::NUM_W-1:0] num;
        bit had_run;
        r = '0;
        if (op == atss_pkg::OP_SUBMIT) begin
            s = NSLOT;
            for (int i = 0; i < NSLOT; i++)
                if (s == NSLOT && m_st[i] == atss_pkg::ST_EMPTY) s = i;
            if (s == NSLOT) begin
                r.status = atss_pkg::STS_FULL;
            end else begin
                m_num[s] = tnum;
                m_wt[s] = '0;
                enter_runnable(s);
                r.submit_slot = s[atss_pkg::SLOT_W-1:0];
            end
        end else begin
            had_run = m_cur < NSLOT;
            if (had_run) begin
                c = m_cur;
                m_cur = NSLOT;
                case (rsn)
                    atss_pkg::RSN_EXIT: begin
                        num = m_num[c];
                        m_st[c] = atss_pkg::ST_EXITED;
                        for (int i = 0; i < NSLOT; i++)
                            if (m_st[i] == atss_pkg::ST_WAITSLEEP && m_wt[i] == num) begin
                                m_wt[i] = '0;
                                enter_runnable(i);
                            end
                    end
                    atss_pkg::RSN_WAIT: begin
                        m_st[c] = atss_pkg::ST_WAITSLEEP;
                        m_wt[c] = wnum;
                    end
                    atss_pkg::RSN_SEGV:  m_st[c] = atss_pkg::ST_EXITED;
                    atss_pkg::RSN_STOP:  m_st[c] = atss_pkg::ST_STOPPED;
                    atss_pkg::RSN_SLEEP: m_st[c] = atss_pkg::ST_SLEEP;
                    default:             enter_runnable(c);
                endcase
            end
            best = NSLOT;
            best_age = '0;
            foreach (m_queue[i]) begin
                s = m_queue[i];
                if (m_age[s] != 16'hffff) m_age[s]++;
                if (best == NSLOT || m_age[s] > best_age) begin
                    best = s;
                    best_age = m_age[s];
                end
            end
            if (best < NSLOT) begin
                foreach (m_queue[i])
                    if (m_queue[i] == best) begin
                        m_queue.delete(i);
                        break;
                    end
                m_st[best] = atss_pkg::ST_RUNNING;
                m_cur = best;
                m_switches++;
                r.chosen_slot = best[atss_pkg::SLOT_W-1:0];
                r.chosen_valid = 1'b1;
            end
            if (!had_run) r.status = atss_pkg::STS_NORUN;
            else if (!r.chosen_valid) r.status = atss_pkg::STS_NONE;
        end
        r.switch_count = m_switches;
        return r;
    endfunction

    task automatic offer(t_row row);
        int gap;
        t_res r;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= row.op;
        i_task_num <= row.tnum;
        i_stop_reason <= row.rsn;
        i_wait_task_num <= row.wnum;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // transfer taken at this edge
        r = schedule_step(row.op, row.tnum, row.rsn, row.wnum);
        pending.push_back(row.typed ? row.res : r);
    endtask

    // receiver: per-result stall plus one long hold-off
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        t_res got, want;
        logic rdy;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_status, o_submit_slot, o_chosen_slot, o_chosen_valid, o_switch_count};
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
                    errors++;
                end
                if (got.submit_slot !== want.submit_slot) begin
                    $display("%0t: submit_slot exp %0d got %0d", $realtime,
                             want.submit_slot, got.submit_slot);
                    errors++;
                end
                if (got.chosen_slot !== want.chosen_slot) begin
                    $display("%0t: chosen_slot exp %0d got %0d", $realtime,
                             want.chosen_slot, got.chosen_slot);
                    errors++;
                end
                if (got.chosen_valid !== want.chosen_valid) begin
                    $display("%0t: chosen_valid exp %0d got %0d", $realtime,
                             want.chosen_valid, got.chosen_valid);
                    errors++;
                end
                if (got.switch_count !== want.switch_count) begin
                    $display("%0t: switch_count exp %0d got %0d", $realtime,
                             want.switch_count, got.switch_count);
                    errors++;
                end
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 3);
        end
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        i_ready <= i_rst_n ? rdy : 1'b0;
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [atss_pkg::NUM_W-1:0] pick_num();
        return ($urandom_range(0, 3) == 0) ? atss_pkg::NUM_W'($urandom)
                                           : atss_pkg::NUM_W'($urandom_range(0, 7));
    endfunction

    t_row dir[$];
    initial begin
        t_row row;
        for (int i = 0; i < NSLOT; i++) begin
            m_num[i] = '0; m_st[i] = atss_pkg::ST_EMPTY; m_age[i] = '0; m_wt[i] = '0;
        end
        m_cur = NSLOT;
        m_switches = '0;

        // schedule straight after reset, submits of the extreme numbers and 5, then all stop reasons
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_PREEMPT, 16'h0, 1,
                        '{atss_pkg::STS_NORUN, 5'd0, 5'd0, 1'b0, 32'd0}});
        dir.push_back('{atss_pkg::OP_SUBMIT, 16'h0, atss_pkg::RSN_PREEMPT, 16'h0, 1,
                        '{atss_pkg::STS_OK, 5'd0, 5'd0, 1'b0, 32'd0}});
        dir.push_back('{atss_pkg::OP_SUBMIT, 16'hffff, RSN_ODD7, 16'hffff, 1,
                        '{atss_pkg::STS_OK, 5'd1, 5'd0, 1'b0, 32'd0}});
        dir.push_back('{atss_pkg::OP_SUBMIT, 16'h5, atss_pkg::RSN_PREEMPT, 16'h0, 1,
                        '{atss_pkg::STS_OK, 5'd2, 5'd0, 1'b0, 32'd0}});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'hffff, atss_pkg::RSN_EXIT, 16'h0, 1,
                        '{atss_pkg::STS_NORUN, 5'd0, 5'd0, 1'b1, 32'd1}});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_WAIT, 16'h5, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, RSN_ODD7, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_EXIT, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SUBMIT, 16'hffff, atss_pkg::RSN_PREEMPT, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SUBMIT, 16'h5, atss_pkg::RSN_PREEMPT, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, RSN_ODD6, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_STOP, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_SLEEP, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_WAIT, 16'hffff, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_SEGV, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_PREEMPT, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_SEGV, 16'h0, 0, '0});
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_PREEMPT, 16'h0, 0, '0});
        // nothing runnable left
        dir.push_back('{atss_pkg::OP_SCHEDULE, 16'h0, atss_pkg::RSN_STOP, 16'h0, 0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[i]) offer(dir[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == 400) begin
                no_gaps = 1;
                hold_req = 1;
            end
            row.op = ($urandom_range(0, 9) < 3) ? atss_pkg::OP_SUBMIT : atss_pkg::OP_SCHEDULE;
            row.tnum = pick_num();
            case ($urandom_range(0, 9)) inside
                [0:3]:   row.rsn = atss_pkg::RSN_PREEMPT;
                [4:5]:   row.rsn = atss_pkg::RSN_WAIT;
                6:       row.rsn = atss_pkg::RSN_EXIT;
                default: row.rsn = atss_pkg::RSN_W'($urandom);
            endcase
            row.wnum = pick_num();
            row.typed = 0;
            row.res = '0;
            offer(row);
        end
        i_valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/atss_pkg.sv
rtl/core/atss_ctrl.sv
rtl/core/atss_dp.sv
rtl/core/aging_task_state_scheduler.sv
tb/tb_aging_task_state_scheduler.sv
